### design/acat017_pkg.sv
`default_nettype none
package acat017_pkg;
  localparam int unsigned CategoryReset = 17;

  localparam logic [4:0] ItemStations  = 5'd3;
  localparam logic [4:0] ItemStation   = 5'd4;
  localparam logic [4:0] ItemTime      = 5'd7;
  localparam logic [4:0] ItemMode3a    = 5'd9;
  localparam logic [4:0] ItemFlevel    = 5'd10;
  localparam logic [4:0] ItemModesCnt  = 5'd14;
  localparam logic [4:0] ItemModesAddr = 5'd15;
  localparam logic [4:0] ItemBlockEnd  = 5'd17;
  localparam logic [4:0] ItemNone      = 5'd31;

  localparam logic [2:0] StatOk        = 3'd0;
  localparam logic [2:0] StatCategory  = 3'd1;
  localparam logic [2:0] StatFspec     = 3'd2;
  localparam logic [2:0] StatRecord    = 3'd3;
  localparam logic [2:0] StatShort     = 3'd4;

  typedef struct packed {
    logic [4:0]  code;
    logic [47:0] value;
    logic        inv;
    logic        garb;
    logic        trk;
    logic [15:0] rec;
    logic        rend;
    logic [2:0]  status;
  } result_t;

  function automatic logic [23:0] sel_mask(input logic [4:0] c);
    case (c)
      5'd0:  sel_mask = 24'h800000;
      5'd1:  sel_mask = 24'h400000;
      5'd2:  sel_mask = 24'h200000;
      5'd3:  sel_mask = 24'h100000;
      5'd5:  sel_mask = 24'h080000;
      5'd6:  sel_mask = 24'h040000;
      5'd7:  sel_mask = 24'h020000;
      5'd8:  sel_mask = 24'h008000;
      5'd9:  sel_mask = 24'h004000;
      5'd10: sel_mask = 24'h002000;
      5'd11: sel_mask = 24'h001000;
      5'd12: sel_mask = 24'h000800;
      5'd13: sel_mask = 24'h000400;
      5'd14: sel_mask = 24'h000200;
      5'd16: sel_mask = 24'h000080;
      default: sel_mask = 24'h000000;
    endcase
  endfunction

  function automatic logic [2:0] item_len(input logic [4:0] c);
    case (c)
      5'd0, 5'd1, 5'd4, 5'd6, 5'd9, 5'd10: item_len = 3'd2;
      5'd5, 5'd7, 5'd15: item_len = 3'd3;
      5'd8:  item_len = 3'd6;
      5'd11: item_len = 3'd4;
      default: item_len = 3'd1;
    endcase
  endfunction

  // Priority search over the 15 presence bits of items 0 to 16 from a starting item.
  function automatic logic [4:0] find_next(input logic [23:0] fs, input logic [4:0] from);
    logic [4:0] r;
    r = ItemNone;
    for (int c = 16; c >= 0; c--) begin
      if (5'(c) >= from && (sel_mask(5'(c)) & fs) != 24'h0) r = 5'(c);
    end
    return r;
  endfunction
endpackage
`default_nettype wire

### design/acat017_core.sv
`default_nettype none
module acat017_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire logic [7:0]            b,
  input  wire logic                  last,
  input  wire logic [7:0]            category,
  output acat017_pkg::result_t       res0,
  output acat017_pkg::result_t       res1,
  output logic [1:0]                 res_count
);
  import acat017_pkg::*;

  logic [1:0]  header_phase, header_phase_next;
  logic [15:0] block_length, block_length_next;
  logic [15:0] byte_position;
  logic [23:0] fspec_bits, fspec_bits_next;
  logic [1:0]  fspec_octets_seen, fspec_octets_seen_next;
  logic [4:0]  current_item, current_item_next;
  logic [2:0]  item_bytes_left, item_bytes_left_next;
  logic [47:0] item_shift, item_shift_next;
  logic [7:0]  list_entries_left, list_entries_left_next;
  logic [15:0] record_count, record_count_next;
  logic        block_error, block_error_next;
  logic [2:0]  error_code, error_code_next;
  logic        reading_fspec, reading_fspec_next;

  logic [47:0] v, val;
  logic [33:0] tprod;
  logic [4:0]  nxt, parent, c0;
  logic [2:0]  status;
  logic        inv, garb, trk, in_body, end_rec;

  always_comb begin
    header_phase_next      = header_phase;
    block_length_next      = block_length;
    fspec_bits_next        = fspec_bits;
    fspec_octets_seen_next = fspec_octets_seen;
    current_item_next      = current_item;
    item_bytes_left_next   = item_bytes_left;
    item_shift_next        = item_shift;
    list_entries_left_next = list_entries_left;
    record_count_next      = record_count;
    block_error_next       = block_error;
    error_code_next        = error_code;
    reading_fspec_next     = reading_fspec;
    res0 = '0;
    res1 = '0;
    res_count = 2'd0;
    v = '0; val = '0; tprod = '0; inv = 1'b0; garb = 1'b0; trk = 1'b0;
    nxt = ItemNone; parent = current_item; c0 = ItemNone; end_rec = 1'b0;
    in_body = 1'b0;
    status = StatOk;

    if (!block_error) begin
      case (header_phase)
        2'd0: begin
          if (b != category) begin
            block_error_next = 1'b1; error_code_next = StatCategory;
          end else header_phase_next = 2'd1;
        end
        2'd1: begin
          block_length_next = {b, 8'h00};
          header_phase_next = 2'd2;
        end
        2'd2: begin
          block_length_next = {block_length[15:8], b};
          header_phase_next = 2'd3;
          if ({block_length[15:8], b} < 16'd3) begin
            block_error_next = 1'b1; error_code_next = StatRecord;
          end
        end
        default: in_body = byte_position < block_length;
      endcase
    end

    if (in_body) begin
      if (reading_fspec) begin
        if (fspec_octets_seen == 2'd0) fspec_bits_next[23:16] = b;
        else if (fspec_octets_seen == 2'd1) fspec_bits_next[15:8] = b;
        else if (fspec_octets_seen == 2'd2) fspec_bits_next[7:0] = b;
        if (fspec_octets_seen != 2'd3) fspec_octets_seen_next = fspec_octets_seen + 2'd1;
        if (!b[0]) begin
          c0 = find_next(fspec_bits_next, 5'd0);
          if (c0 == ItemNone) end_rec = 1'b1;
          else begin
            reading_fspec_next   = 1'b0;
            current_item_next    = c0;
            item_bytes_left_next = item_len(c0);
            item_shift_next      = '0;
          end
        end
      end else begin
        v = {item_shift[39:0], b};
        item_shift_next = v;
        if (item_bytes_left > 3'd0) item_bytes_left_next = item_bytes_left - 3'd1;
        if (item_bytes_left <= 3'd1) begin
          tprod = 34'(v[23:0]) * 34'd1000 + 34'd64;
          case (current_item)
            5'd0, 5'd1, 5'd4: val = {32'h0, v[15:0]};
            5'd5, 5'd15:      val = {24'h0, v[23:0]};
            5'd6:             val = {36'h0, v[11:0]};
            ItemTime:         val = {21'h0, tprod[33:7]};
            5'd8:             val = v;
            ItemMode3a: begin
              inv = v[15]; garb = v[14]; trk = v[13]; val = {36'h0, v[11:0]};
            end
            ItemFlevel: begin
              inv = v[15]; garb = v[14]; val = {34'h0, v[13:0]};
            end
            5'd11:            val = {16'h0, v[31:0]};
            default:          val = {40'h0, v[7:0]};
          endcase
          res_count = 2'd1;
          res0.code = current_item;
          res0.value = val;
          res0.rec = record_count;
          if ((current_item == ItemStations || current_item == ItemModesCnt)
              && val[7:0] != 8'd0) begin
            list_entries_left_next = val[7:0];
            current_item_next      = current_item + 5'd1;
            item_bytes_left_next   = item_len(current_item + 5'd1);
            item_shift_next        = '0;
          end else if ((current_item == ItemStation || current_item == ItemModesAddr)
                       && list_entries_left > 8'd1) begin
            list_entries_left_next = list_entries_left - 8'd1;
            item_bytes_left_next   = item_len(current_item);
            item_shift_next        = '0;
          end else begin
            if (current_item == ItemStation || current_item == ItemModesAddr) begin
              list_entries_left_next = 8'd0;
              parent = current_item - 5'd1;
            end
            nxt = find_next(fspec_bits, parent + 5'd1);
            res0.inv = inv; res0.garb = garb; res0.trk = trk;
            res0.rend = (nxt == ItemNone);
            if (nxt == ItemNone) end_rec = 1'b1;
            else begin
              current_item_next    = nxt;
              item_bytes_left_next = item_len(nxt);
              item_shift_next      = '0;
            end
          end
        end
      end
      if (end_rec) begin
        record_count_next      = record_count + 16'd1;
        fspec_bits_next        = '0;
        fspec_octets_seen_next = 2'd0;
        reading_fspec_next     = 1'b1;
        current_item_next      = 5'd0;
        item_bytes_left_next   = 3'd0;
        item_shift_next        = '0;
        list_entries_left_next = 8'd0;
      end
      if (byte_position + 16'd1 == block_length && !block_error) begin
        if (reading_fspec_next) begin
          if (fspec_octets_seen_next != 2'd0) begin
            block_error_next = 1'b1; error_code_next = StatFspec;
          end
        end else begin
          block_error_next = 1'b1; error_code_next = StatRecord;
        end
      end
    end

    if (last) begin
      status = block_error_next ? error_code_next : StatOk;
      if (status != StatCategory &&
          (header_phase_next != 2'd3 || 17'(byte_position) + 17'd1 < 17'(block_length_next)))
        status = StatShort;
      if (res_count == 2'd0) begin
        res0.code = ItemBlockEnd; res0.value = {32'h0, record_count_next};
        res0.rec = record_count_next; res0.status = status;
      end else begin
        res1.code = ItemBlockEnd; res1.value = {32'h0, record_count_next};
        res1.rec = record_count_next; res1.status = status;
      end
      res_count = res_count + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      header_phase <= '0; block_length <= '0; byte_position <= '0;
      fspec_bits <= '0; fspec_octets_seen <= '0; current_item <= '0;
      item_bytes_left <= '0; item_shift <= '0; list_entries_left <= '0;
      record_count <= '0; block_error <= 1'b0; error_code <= StatOk;
      reading_fspec <= 1'b1;
    end else if (step) begin
      header_phase <= header_phase_next; block_length <= block_length_next;
      if (byte_position != 16'hFFFF) byte_position <= byte_position + 16'd1;
      fspec_bits <= fspec_bits_next; fspec_octets_seen <= fspec_octets_seen_next;
      current_item <= current_item_next; item_bytes_left <= item_bytes_left_next;
      item_shift <= item_shift_next; list_entries_left <= list_entries_left_next;
      record_count <= record_count_next; block_error <= block_error_next;
      error_code <= error_code_next; reading_fspec <= reading_fspec_next;
    end
  end
endmodule
`default_nettype wire

### design/acat017_outq.sv
`default_nettype none
module acat017_outq (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire logic [1:0]            push_count,
  input  wire acat017_pkg::result_t  push0,
  input  wire acat017_pkg::result_t  push1,
  output logic                       room,
  output logic                       m_valid,
  input  wire logic                  m_ready,
  output acat017_pkg::result_t       m_data
);
  import acat017_pkg::*;

  // Four-entry queue; a push of up to two results needs two free slots.
  result_t    mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] fill;
  logic       pop;

  assign pop     = m_valid && m_ready;
  assign m_valid = fill != 3'd0;
  assign m_data  = mem[rd_ptr];
  assign room    = fill <= 3'd2;

  always_ff @(posedge clk) begin
    if (push && push_count != 2'd0) mem[wr_ptr] <= push0;
    if (push && push_count == 2'd2) mem[wr_ptr + 2'd1] <= push1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0; rd_ptr <= '0; fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + push_count;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + (push ? {1'b0, push_count} : 3'd0) - {2'b0, pop};
    end
  end
endmodule
`default_nettype wire

### design/asterix_cat017_record_decoder.sv
`default_nettype none
// ASTERIX category 017 block decoder. Bytes of a data block enter on the s_axis
// side one item per cycle (tlast marks the final delivered byte); each decoded
// data item leaves on m_axis, with a block-end item closing every block and
// carrying its status. An accepted byte is registered, decoded while the output
// queue has two free slots and yields up to two results into that four-entry
// queue; input ready holds high while the queue has two free slots, so a byte
// per cycle is sustained whenever the consumer takes results as fast as they
// are made. Write cfg only while idle.
module asterix_cat017_record_decoder #(
  parameter logic [7:0] CAT_RESET = 8'(acat017_pkg::CategoryReset)
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic        s_axis_tlast,   // block_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata from bit 0: item_value[47:0], flag_invalid, flag_garbled, flag_tracked,
  // record_number[15:0], record_end, block_status[2:0], zero pad to 72 bits
  output logic [71:0]      m_axis_tdata,
  output logic [4:0]       m_axis_tuser,   // item_code
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data        // expected_category
);
  import acat017_pkg::*;

  result_t    r0, r1, q;
  logic [1:0] rc;
  logic [7:0] category, in_byte;
  logic       in_last, in_valid, room;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) category <= CAT_RESET;
    else if (cfg_valid) category <= cfg_data;
  end

  // Input register: hold the byte until the decoder takes it.
  // The decoder commits an item only when two queue slots are free.
  assign s_axis_tready = !in_valid || room;
  always_ff @(posedge clk) begin
    if (rst) in_valid <= 1'b0;
    else if (s_axis_tready) in_valid <= s_axis_tvalid;
    if (s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  acat017_core u_core (
    .clk, .rst, .step(in_valid && room), .b(in_byte), .last(in_last),
    .category, .res0(r0), .res1(r1), .res_count(rc)
  );

  acat017_outq u_outq (
    .clk, .rst, .push(in_valid && room), .push_count(rc), .push0(r0), .push1(r1),
    .room, .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_data(q)
  );

  assign m_axis_tuser = q.code;
  assign m_axis_tdata = {1'b0, q.status, q.rend, q.rec, q.trk, q.garb, q.inv, q.value};
endmodule
`default_nettype wire

### design/acat017_checker.sv
`default_nettype none
module acat017_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [71:0] m_axis_tdata,
  input wire logic [4:0]  m_axis_tuser
);
  import acat017_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");
  a_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser <= ItemBlockEnd)
    else $error("bad item code");
  a_stat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ItemBlockEnd |-> m_axis_tdata[70:68] == StatOk)
    else $error("status on data item");
  a_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ItemBlockEnd |-> !m_axis_tdata[67])
    else $error("record end on block end");
endmodule

bind asterix_cat017_record_decoder acat017_checker u_chk (.*);
`default_nettype wire

### verif/acat017_decode_checker.sv
`default_nettype none
module acat017_decode_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic        s_axis_tlast,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [71:0] m_axis_tdata,
  input  wire logic [4:0]  m_axis_tuser,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [7:0]  cfg_data,
  output int               fail_count,
  output int               pending_count
);
  import acat017_pkg::*;

  localparam logic [23:0] PRESENCE [17] = '{
    24'h800000, 24'h400000, 24'h200000, 24'h100000, 24'h000000, 24'h080000,
    24'h040000, 24'h020000, 24'h008000, 24'h004000, 24'h002000, 24'h001000,
    24'h000800, 24'h000400, 24'h000200, 24'h000000, 24'h000080};
  localparam logic [2:0] OCTETS [17] = '{
    3'd2, 3'd2, 3'd1, 3'd1, 3'd2, 3'd3, 3'd2, 3'd3, 3'd6, 3'd2, 3'd2, 3'd4,
    3'd1, 3'd1, 3'd1, 3'd3, 3'd1};

  result_t     decoded_q[$];
  logic [7:0]  category;
  logic [1:0]  hdr_phase;
  logic [15:0] blk_len, byte_pos, rec_cnt;
  logic [23:0] fspec;
  logic [1:0]  fspec_seen;
  logic [4:0]  cur_item;
  logic [2:0]  octets_left;
  logic [47:0] shift_reg;
  logic [7:0]  list_left;
  logic        blk_err, in_fspec;
  logic [2:0]  err_code;

  assign pending_count = decoded_q.size();

  task automatic clear_block();
    hdr_phase = '0; blk_len = '0; byte_pos = '0; fspec = '0; fspec_seen = '0;
    cur_item = '0; octets_left = '0; shift_reg = '0; list_left = '0; rec_cnt = '0;
    blk_err = 1'b0; err_code = StatOk; in_fspec = 1'b1;
  endtask

  task automatic flag_error(input logic [2:0] code);
    if (!blk_err) begin
      blk_err = 1'b1;
      err_code = code;
    end
  endtask

  task automatic push(input logic [4:0] code, input logic [47:0] val, input logic inv,
                      input logic garb, input logic trk, input logic rend,
                      input logic [2:0] stat);
    result_t r;
    r.code = code; r.value = val; r.inv = inv; r.garb = garb; r.trk = trk;
    r.rec = rec_cnt; r.rend = rend; r.status = stat;
    decoded_q = {decoded_q, r};
  endtask

  function automatic logic [4:0] next_present(input int from);
    for (int c = from; c < 17; c++)
      if ((PRESENCE[c] & fspec) != 24'h0) return 5'(c);
    return ItemNone;
  endfunction

  task automatic open_item(input logic [4:0] c);
    cur_item = c;
    octets_left = (c < 5'd17) ? OCTETS[c] : 3'd1;
    shift_reg = '0;
  endtask

  task automatic close_record();
    rec_cnt = rec_cnt + 16'd1;
    fspec = '0; fspec_seen = '0; in_fspec = 1'b1; cur_item = '0;
    octets_left = '0; shift_reg = '0; list_left = '0;
  endtask

  task automatic complete_item();
    logic [4:0]  parent, nxt;
    logic [47:0] val;
    logic [63:0] ms;
    logic        inv, garb, trk;
    parent = cur_item; inv = 1'b0; garb = 1'b0; trk = 1'b0;
    case (cur_item)
      5'd0, 5'd1, ItemStation: val = shift_reg & 48'hFFFF;
      5'd5, ItemModesAddr: val = shift_reg & 48'hFFFFFF;
      5'd6: val = shift_reg & 48'hFFF;
      ItemTime: begin
        ms = ({40'd0, shift_reg[23:0]} * 64'd1000 + 64'd64) >> 7;
        val = ms[47:0];
      end
      5'd8: val = shift_reg;
      ItemMode3a: begin
        inv = shift_reg[15]; garb = shift_reg[14]; trk = shift_reg[13];
        val = shift_reg & 48'hFFF;
      end
      ItemFlevel: begin
        inv = shift_reg[15]; garb = shift_reg[14];
        val = shift_reg & 48'h3FFF;
      end
      5'd11: val = shift_reg & 48'hFFFFFFFF;
      default: val = shift_reg & 48'hFF;
    endcase
    if ((cur_item == ItemStations || cur_item == ItemModesCnt) && val != 48'h0) begin
      list_left = val[7:0];
      push(cur_item, val, 1'b0, 1'b0, 1'b0, 1'b0, StatOk);
      open_item(cur_item + 5'd1);
      return;
    end
    if (cur_item == ItemStation || cur_item == ItemModesAddr) begin
      if (list_left > 8'd1) begin
        list_left--;
        push(cur_item, val, 1'b0, 1'b0, 1'b0, 1'b0, StatOk);
        open_item(cur_item);
        return;
      end
      list_left = '0;
      parent = cur_item - 5'd1;
    end
    nxt = next_present(int'(parent) + 1);
    push(cur_item, val, inv, garb, trk, nxt == ItemNone, StatOk);
    if (nxt == ItemNone) close_record();
    else open_item(nxt);
  endtask

  task automatic body_octet(input logic [7:0] b);
    logic [4:0] c;
    if (in_fspec) begin
      if (fspec_seen < 2'd3) begin
        fspec = fspec | ({16'd0, b} << (16 - 8 * fspec_seen));
        fspec_seen++;
      end
      if (b[0]) return;
      in_fspec = 1'b0;
      c = next_present(0);
      if (c == ItemNone) close_record();
      else open_item(c);
      return;
    end
    shift_reg = {shift_reg[39:0], b};
    if (octets_left > 3'd0) octets_left--;
    if (octets_left == 3'd0) complete_item();
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic [16:0] idx;
    logic [2:0]  stat;
    idx = {1'b0, byte_pos};
    if (!blk_err) begin
      if (hdr_phase == 2'd0) begin
        if (b != category) flag_error(StatCategory);
        else hdr_phase = 2'd1;
      end else if (hdr_phase == 2'd1) begin
        blk_len = {b, 8'd0};
        hdr_phase = 2'd2;
      end else if (hdr_phase == 2'd2) begin
        blk_len = blk_len | {8'd0, b};
        hdr_phase = 2'd3;
        if (blk_len < 16'd3) flag_error(StatRecord);
      end else if (idx < {1'b0, blk_len}) begin
        body_octet(b);
        if (idx + 17'd1 == {1'b0, blk_len}) begin
          if (in_fspec) begin
            if (fspec_seen > 2'd0) flag_error(StatFspec);
          end else flag_error(StatRecord);
        end
      end
    end
    if (byte_pos != 16'hFFFF) byte_pos++;
    if (last) begin
      stat = blk_err ? err_code : StatOk;
      if (stat != StatCategory && (hdr_phase < 2'd3 || idx + 17'd1 < {1'b0, blk_len}))
        stat = StatShort;
      push(ItemBlockEnd, {32'd0, rec_cnt}, 1'b0, 1'b0, 1'b0, 1'b0, stat);
      clear_block();
    end
  endtask

  task automatic compare(input string name, input logic [47:0] want, input logic [47:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      category = 8'(CategoryReset);
      clear_block();
      decoded_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) category = cfg_data;
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_q.size() == 0) begin
          $error("result with no item pending: code %0d", m_axis_tuser);
          fail_count++;
        end else begin
          want = decoded_q[0];
          decoded_q.delete(0);
          compare("item_code", 48'(want.code), 48'(m_axis_tuser));
          compare("item_value", want.value, m_axis_tdata[47:0]);
          compare("flag_invalid", 48'(want.inv), 48'(m_axis_tdata[48]));
          compare("flag_garbled", 48'(want.garb), 48'(m_axis_tdata[49]));
          compare("flag_tracked", 48'(want.trk), 48'(m_axis_tdata[50]));
          compare("record_number", 48'(want.rec), 48'(m_axis_tdata[66:51]));
          compare("record_end", 48'(want.rend), 48'(m_axis_tdata[67]));
          compare("block_status", 48'(want.status), 48'(m_axis_tdata[70:68]));
        end
      end
    end
  end
endmodule
`default_nettype wire

### verif/asterix_cat017_record_decoder_tb.sv
`default_nettype none
module asterix_cat017_record_decoder_tb;
  import acat017_pkg::*;

  localparam logic [7:0] CAT_DEFAULT = 8'(CategoryReset);
  localparam logic [2:0] ITEM_OCTETS [17] = '{
    3'd2, 3'd2, 3'd1, 3'd1, 3'd2, 3'd3, 3'd2, 3'd3, 3'd6, 3'd2, 3'd2, 3'd4,
    3'd1, 3'd1, 3'd1, 3'd3, 3'd1};
  localparam logic [23:0] ITEM_BIT [17] = '{
    24'h800000, 24'h400000, 24'h200000, 24'h100000, 24'h000000, 24'h080000,
    24'h040000, 24'h020000, 24'h008000, 24'h004000, 24'h002000, 24'h001000,
    24'h000800, 24'h000400, 24'h000200, 24'h000000, 24'h000080};

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 0;   // data_byte
  logic        s_axis_tlast = 0;   // block_last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [71:0] m_axis_tdata;       // item_value, flags, record_number, record_end, status
  logic [4:0]  m_axis_tuser;       // item_code
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 0;       // expected_category

  int          fail_count, pending_count;
  int          tx_idle_pct = 0, rx_idle_pct = 0;
  int          bytes_sent = 0;
  logic        hold_go = 0;
  logic [7:0]  cur_category = CAT_DEFAULT;
  logic [7:0]  frame_q[$];

  asterix_cat017_record_decoder u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  acat017_decode_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Receiver: random back-pressure, plus one long hold-off counted here so the
  // output queue fills and the block stalls its input.
  always @(negedge clk) begin
    static int  hold_left = 0;
    static bit  hold_done = 0;
    if (hold_go && !hold_done) begin
      hold_left = 300;
      hold_done = 1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offer one item; idle gaps go in front, then hold it until accepted.
  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    forever begin
      @(posedge clk);
      if (s_axis_tready) break;
    end
    bytes_sent++;
  endtask

  // Send the frame queue, tlast on its final byte, then drop valid.
  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    frame_q.delete();
  endtask

  task automatic wait_drained();
    while (pending_count != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_category(input logic [7:0] c);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_category = c;
  endtask

  // Append one well-formed record with random content to the body.
  task automatic build_record(ref logic [7:0] body[$]);
    logic [7:0]  oct [4];
    logic [23:0] sel;
    int          n_oct, cnt;
    n_oct = ($urandom_range(19) == 0) ? 4 : $urandom_range(1, 3);
    for (int i = 0; i < 4; i++) oct[i] = 8'($urandom) & 8'hFE;
    for (int i = 0; i < n_oct; i++) body = {body, oct[i] | 8'(i < n_oct - 1)};
    sel = {oct[0], (n_oct > 1) ? oct[1] : 8'd0, (n_oct > 2) ? oct[2] : 8'd0};
    for (int c = 0; c < 17; c++) begin
      if ((ITEM_BIT[c] & sel) == 0) continue;
      if (c == ItemStations || c == ItemModesCnt) begin
        cnt = $urandom_range(0, 3);
        body = {body, 8'(cnt)};
        repeat (cnt * ITEM_OCTETS[c + 1]) body = {body, 8'($urandom)};
      end else begin
        repeat (ITEM_OCTETS[c]) body = {body, 8'($urandom)};
      end
    end
  endtask

  // Build one block: mostly well formed, the rest cut short, overlong,
  // mislabelled or plain noise.
  task automatic build_block();
    logic [7:0] body[$];
    int         kind, len, cut;
    kind = $urandom_range(99);
    if (kind >= 96) begin
      repeat ($urandom_range(1, 8)) frame_q = {frame_q, 8'($urandom)};
      return;
    end
    repeat ($urandom_range(1, 3)) build_record(body);
    len = body.size() + 3;
    if (kind >= 70 && kind < 78) len = len - $urandom_range(1, 3);
    frame_q = {frame_q, (kind >= 91) ? 8'($urandom) : cur_category};
    frame_q = {frame_q, 8'(len >> 8)};
    frame_q = {frame_q, 8'(len)};
    foreach (body[i]) frame_q = {frame_q, body[i]};
    if (kind >= 78 && kind < 85) begin
      cut = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end
    if (kind >= 85 && kind < 91)
      repeat ($urandom_range(1, 4)) frame_q = {frame_q, 8'($urandom)};
  endtask

  initial begin
    #(8 * 200000);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [7:0] settings [4];
    settings = '{8'd17, 8'd0, 8'd255, 8'($urandom)};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: wrong category, short length, header cut, empty record, FSPEC
    // chained past the length, item unfinished at the length, four-octet FSPEC.
    frame_q = '{8'd18, 8'h00}; send_frame();
    frame_q = '{CAT_DEFAULT, 8'h00, 8'h02}; send_frame();
    frame_q = '{CAT_DEFAULT}; send_frame();
    frame_q = '{CAT_DEFAULT, 8'h00, 8'h04, 8'h00}; send_frame();
    frame_q = '{CAT_DEFAULT, 8'h00, 8'h04, 8'hFF}; send_frame();
    frame_q = '{CAT_DEFAULT, 8'h00, 8'h05, 8'h80, 8'hAB}; send_frame();
    frame_q = '{CAT_DEFAULT, 8'h00, 8'h0B, 8'h03, 8'h01, 8'h01, 8'h00,
                8'h02, 8'hFF, 8'h00, 8'h01}; send_frame();

    for (int p = 0; p < 4; p++) begin
      write_category(settings[p]);
      case (p)
        0: begin tx_idle_pct = 20; rx_idle_pct = 72; end
        1: begin tx_idle_pct = 72; rx_idle_pct = 20; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      if (p == 3) hold_go = 1'b1;
      while (bytes_sent < 190 * (p + 1)) begin
        if ($urandom_range(19) == 0) wait_drained();
        build_block();
        send_frame();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      if (pending_count != 0) $error("%0d results never arrived", pending_count);
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
